>>> rtl/ddmv_pkg.sv
// ddmv_pkg: shared types, constants and helpers for the differential drive
// motor velocity unit. No dependencies; every rtl module imports it.

package ddmv_pkg;

  // Default fraction bits of the command words
  localparam int CMD_FRAC_BITS_DEF = 12;

  // Sim-mode linear gain polynomial, Q0.16
  localparam logic [14:0] LINFAC_A = 15'd28528;
  localparam logic [14:0] LINFAC_B = 15'd20080;
  // 2*pi/60 in Q0.32
  localparam logic [28:0] RPM_TO_RADS = 29'd449767923;

  // One quotient bit per divider stage
  localparam int DIV_STEPS = 32;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_DRIVE_MODE,
    REG_RATED_RPM,
    REG_SIM_SPEED_LIMIT,
    REG_LINEAR_GAIN,
    REG_ANGULAR_GAIN,
    REG_LINEAR_LIMIT,
    REG_ANGULAR_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic        drive_mode;
    logic [15:0] rated_rpm;
    logic [14:0] sim_speed_limit;
    logic [14:0] linear_gain;
    logic [14:0] angular_gain;
    logic [14:0] linear_limit;
    logic [14:0] angular_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    drive_mode:      1'b0,
    rated_rpm:       16'd1000,
    sim_speed_limit: 15'd12288,
    linear_gain:     15'd4096,
    angular_gain:    15'd4096,
    linear_limit:    15'd8192,
    angular_limit:   15'd8192
  };

  // Command word
  typedef struct packed {
    logic signed [15:0] lin_x;
    logic signed [15:0] lin_y;
    logic signed [15:0] lin_z;
    logic signed [15:0] ang_x;
    logic signed [15:0] ang_y;
    logic signed [15:0] ang_z;
  } cmd_t;

  // Speed word
  typedef struct packed {
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic               div_fault;
  } spd_t;

  // Side information carried alongside the divider
  typedef struct packed {
    logic               any;       // command not all zero
    logic               sim;       // sim kinematics selected
    logic signed [19:0] sim_left;  // finished sim results, Q.16
    logic signed [19:0] sim_right;
    logic               zero_l;    // motor term is zero
    logic               zero_r;
    logic               sat_l;     // ratio saturates at one
    logic               sat_r;
    logic               neg_l;     // sign of the result
    logic               neg_r;
    logic               den_zero;  // reachable speed is zero
  } tag_t;

  // Front end to divider
  typedef struct packed {
    tag_t        tag;
    logic [53:0] n_l;
    logic [53:0] n_r;
    logic [53:0] d;
  } fe_t;

  // Divider to back end
  typedef struct packed {
    tag_t        tag;
    logic [31:0] q_l;
    logic [31:0] q_r;
  } bk_t;

  // Signed clamp by magnitude, result fits Q.16 in 20 bits
  function automatic logic signed [19:0] sim_clamp(logic signed [24:0] v,
                                                   logic [18:0] lim);
    logic [24:0] mag;
    logic [18:0] m;
    mag = v[24] ? 25'(-v) : 25'(v);
    m   = (mag > 25'(lim)) ? lim : mag[18:0];
    return v[24] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

>>> rtl/ddmv_front.sv
// ddmv_front: command clamp, sim-mode arithmetic and divider operand set-up
// in five register stages. Depends on ddmv_pkg.

module ddmv_front import ddmv_pkg::*; #(
  parameter int CMD_FRAC_BITS = CMD_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic up_valid,
  output logic up_ready,
  input  cmd_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output fe_t  dn_data
);

  localparam int SH = 16 - CMD_FRAC_BITS;
  localparam int MW = 17 + SH;
  localparam int CW = (MW > 19) ? MW : 19;

  logic en1, en2, en3, en4, en5;
  logic v1, v2, v3, v4, v5;

  // stage 1 regs
  logic        any1, sim1, xn1, zn1;
  logic [18:0] xm1, zm1;
  // stage 2 regs
  logic        any2, sim2, xn2, zn2, zz2;
  logic [18:0] xm2, zm2;
  logic [37:0] ax2_2;
  logic [33:0] axb2, angm2, linm2;
  logic [29:0] p2, q2;
  // stage 3 regs
  logic               any3, sim3, xn3, zn3;
  logic [52:0]        t1_3;
  logic [33:0]        axb3, angm3;
  logic signed [35:0] motl3, motr3;
  logic [48:0]        ta3;
  logic signed [50:0] tb3;
  logic [18:0]        aden3;
  // stage 4 regs
  logic               any4, sim4, xn4, zn4;
  logic [21:0]        lm4;
  logic [22:0]        am4;
  logic signed [50:0] den4;
  logic [53:0]        nl4, nr4;
  logic               zl4, zr4, mln4, mrn4;

  // stall chain, each stage moves when empty or its successor moves
  assign en5      = !v5 || dn_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign up_ready = en1;
  assign dn_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1: zero test, widen to Q.16 and clamp by magnitude
  logic [16:0]   xabs, zabs;
  logic [CW-1:0] xq, zq;
  logic [18:0]   xlim, zlim, xm_c, zm_c;

  always_comb begin
    xabs = up_data.lin_x[15] ? 17'd0 - 17'(up_data.lin_x) : 17'(up_data.lin_x);
    zabs = up_data.ang_z[15] ? 17'd0 - 17'(up_data.ang_z) : 17'(up_data.ang_z);
    xq   = CW'(xabs) << SH;
    zq   = CW'(zabs) << SH;
    xlim = {cfg.linear_limit, 4'b0};
    zlim = {cfg.angular_limit, 4'b0};
    xm_c = (xq > CW'(xlim)) ? xlim : xq[18:0];
    zm_c = (zq > CW'(zlim)) ? zlim : zq[18:0];
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      any1 <= |{up_data.lin_x, up_data.lin_y, up_data.lin_z,
                up_data.ang_x, up_data.ang_y, up_data.ang_z};
      sim1 <= !cfg.drive_mode;
      xm1  <= xm_c;
      zm1  <= zm_c;
      xn1  <= up_data.lin_x[15] && (xm_c != '0);
      zn1  <= up_data.ang_z[15] && (zm_c != '0);
    end
  end

  // stage 2: first products
  always_ff @(posedge clk) begin
    if (en2) begin
      any2  <= any1;
      sim2  <= sim1;
      xn2   <= xn1;
      zn2   <= zn1;
      zz2   <= (zm1 == '0);
      xm2   <= xm1;
      zm2   <= zm1;
      ax2_2 <= 38'(xm1) * 38'(xm1);
      axb2  <= 34'(LINFAC_B) * 34'(xm1);
      angm2 <= 34'(cfg.angular_gain) * 34'(zm1);
      linm2 <= 34'(cfg.linear_gain) * 34'(xm1);
      p2    <= 30'(cfg.linear_gain) * 30'(cfg.linear_limit);
      q2    <= 30'(cfg.angular_gain) * 30'(cfg.angular_limit);
    end
  end

  // stage 3: quadratic term, signed motor terms, divisor products
  logic signed [34:0] lin_s, ang_s;
  logic [18:0]        ax_c, ad_c;
  logic signed [19:0] dax;

  always_comb begin
    lin_s = xn2 ? -$signed({1'b0, linm2}) : $signed({1'b0, linm2});
    ang_s = zn2 ? -$signed({1'b0, angm2}) : $signed({1'b0, angm2});
    ax_c  = zz2 ? 19'd1 : xm2;
    ad_c  = zz2 ? 19'd1 : zm2;
    dax   = $signed({1'b0, ad_c}) - $signed({1'b0, ax_c});
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      any3  <= any2;
      sim3  <= sim2;
      xn3   <= xn2;
      zn3   <= zn2;
      t1_3  <= 53'(LINFAC_A) * 53'(ax2_2);
      axb3  <= axb2;
      angm3 <= angm2;
      motl3 <= 36'(lin_s) - 36'(ang_s);
      motr3 <= 36'(lin_s) + 36'(ang_s);
      ta3   <= 49'(ax_c) * 49'(p2);
      tb3   <= 51'(dax) * $signed({21'b0, q2});
      aden3 <= ad_c;
    end
  end

  // stage 4: rounding of sim terms, divisor sum, dividends
  logic [53:0] lsum;
  logic [34:0] asum;
  logic [35:0] magl, magr;

  always_comb begin
    lsum = 54'(t1_3) + {4'b0, axb3, 16'b0} + 54'h8000_0000;
    asum = 35'(angm3) + 35'h800;
    magl = motl3[35] ? 36'(-motl3) : 36'(motl3);
    magr = motr3[35] ? 36'(-motr3) : 36'(motr3);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      any4 <= any3;
      sim4 <= sim3;
      xn4  <= xn3;
      zn4  <= zn3;
      lm4  <= lsum[53:32];
      am4  <= asum[34:12];
      den4 <= $signed({2'b0, ta3}) + tb3;
      nl4  <= 54'(magl[34:0]) * 54'(aden3);
      nr4  <= 54'(magr[34:0]) * 54'(aden3);
      zl4  <= (motl3 == '0);
      zr4  <= (motr3 == '0);
      mln4 <= motl3[35];
      mrn4 <= motr3[35];
    end
  end

  // stage 5: sim motor mix and clamp, divisor magnitude and saturation test
  logic signed [23:0] lin24, ang24;
  logic [50:0]        absden;
  logic [53:0]        d_c;
  logic               dz;

  always_comb begin
    lin24  = xn4 ? -$signed({2'b0, lm4}) : $signed({2'b0, lm4});
    ang24  = zn4 ? -$signed({1'b0, am4}) : $signed({1'b0, am4});
    absden = den4[50] ? 51'(-den4) : 51'(den4);
    d_c    = {absden[49:0], 4'b0};
    dz     = (den4 == '0);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      dn_data.tag.any       <= any4;
      dn_data.tag.sim       <= sim4;
      dn_data.tag.sim_left  <= sim_clamp(25'(lin24) - 25'(ang24),
                                         {cfg.sim_speed_limit, 4'b0});
      dn_data.tag.sim_right <= sim_clamp(25'(lin24) + 25'(ang24),
                                         {cfg.sim_speed_limit, 4'b0});
      dn_data.tag.zero_l    <= zl4;
      dn_data.tag.zero_r    <= zr4;
      dn_data.tag.sat_l     <= dz || (nl4 >= d_c);
      dn_data.tag.sat_r     <= dz || (nr4 >= d_c);
      dn_data.tag.neg_l     <= dz ? mln4 : (mln4 ^ den4[50]);
      dn_data.tag.neg_r     <= dz ? mrn4 : (mrn4 ^ den4[50]);
      dn_data.tag.den_zero  <= dz;
      dn_data.n_l           <= nl4;
      dn_data.n_r           <= nr4;
      dn_data.d             <= d_c;
    end
  end

endmodule

>>> rtl/ddmv_divider.sv
// ddmv_divider: two-lane restoring fraction divider, one quotient bit per
// register stage. Depends on ddmv_pkg.

module ddmv_divider import ddmv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  fe_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output bk_t  dn_data
);

  typedef struct packed {
    tag_t        tag;
    logic [53:0] rem_l;
    logic [53:0] rem_r;
    logic [53:0] d;
    logic [31:0] q_l;
    logic [31:0] q_r;
  } dv_t;

  typedef struct packed {
    logic [53:0] rem;
    logic [31:0] q;
  } lane_t;

  dv_t              st  [DIV_STEPS];
  dv_t              nxt [DIV_STEPS];
  logic [DIV_STEPS-1:0] v;
  logic [DIV_STEPS:0]   en;

  // one shift, compare and subtract
  function automatic lane_t div_step(logic [53:0] rem, logic [31:0] q,
                                     logic [53:0] d);
    logic [54:0] r2;
    lane_t       res;
    r2 = {rem, 1'b0};
    if (r2 >= {1'b0, d}) begin
      res.rem = 54'(r2 - {1'b0, d});
      res.q   = {q[30:0], 1'b1};
    end else begin
      res.rem = r2[53:0];
      res.q   = {q[30:0], 1'b0};
    end
    return res;
  endfunction

  // stall chain
  always_comb begin
    en[DIV_STEPS] = dn_ready;
    for (int k = DIV_STEPS - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign up_ready = en[0];

  // per-stage step
  always_comb begin
    dv_t   src;
    lane_t ll, lr;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        src.tag   = up_data.tag;
        src.rem_l = up_data.n_l;
        src.rem_r = up_data.n_r;
        src.d     = up_data.d;
        src.q_l   = '0;
        src.q_r   = '0;
      end else begin
        src = st[k-1];
      end
      ll = div_step(src.rem_l, src.q_l, src.d);
      lr = div_step(src.rem_r, src.q_r, src.d);
      nxt[k]       = src;
      nxt[k].rem_l = ll.rem;
      nxt[k].q_l   = ll.q;
      nxt[k].rem_r = lr.rem;
      nxt[k].q_r   = lr.q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (en[k]) v[k] <= (k == 0) ? up_valid : v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (en[k]) st[k] <= nxt[k];
    end
  end

  assign dn_valid    = v[DIV_STEPS-1];
  assign dn_data.tag = st[DIV_STEPS-1].tag;
  assign dn_data.q_l = st[DIV_STEPS-1].q_l;
  assign dn_data.q_r = st[DIV_STEPS-1].q_r;

endmodule

>>> rtl/ddmv_back.sv
// ddmv_back: rpm scaling, rpm to rad/s conversion and result selection in
// four register stages, the last being the output word. Depends on ddmv_pkg.

module ddmv_back import ddmv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic up_valid,
  output logic up_ready,
  input  bk_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output spd_t dn_data
);

  logic en1, en2, en3, en4;
  logic v1, v2, v3, v4;

  tag_t        tag1, tag2, tag3;
  logic [47:0] m1l, m1r;
  logic [32:0] m2l, m2r;
  logic [61:0] m3l, m3r;

  assign en4      = !v4 || dn_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign up_ready = en1;
  assign dn_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: rpm times ratio, saturated ratio is exactly one
  logic [32:0] fl, fr;

  always_comb begin
    fl = up_data.tag.sat_l ? 33'h1_0000_0000 : {1'b0, up_data.q_l};
    fr = up_data.tag.sat_r ? 33'h1_0000_0000 : {1'b0, up_data.q_r};
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      tag1 <= up_data.tag;
      m1l  <= 48'(cfg.rated_rpm) * 48'(fl);
      m1r  <= 48'(cfg.rated_rpm) * 48'(fr);
    end
  end

  // stage 2: round to Q.16
  logic [48:0] s2l, s2r;

  always_comb begin
    s2l = {1'b0, m1l} + 49'h8000;
    s2r = {1'b0, m1r} + 49'h8000;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      tag2 <= tag1;
      m2l  <= s2l[48:16];
      m2r  <= s2r[48:16];
    end
  end

  // stage 3: rpm to rad/s
  always_ff @(posedge clk) begin
    if (en3) begin
      tag3 <= tag2;
      m3l  <= 62'(m2l) * 62'(RPM_TO_RADS);
      m3r  <= 62'(m2r) * 62'(RPM_TO_RADS);
    end
  end

  // stage 4: round, apply sign, pick mode
  logic [62:0]        s4l, s4r;
  logic signed [31:0] dl, dr;

  always_comb begin
    s4l = {1'b0, m3l} + 63'h8000_0000;
    s4r = {1'b0, m3r} + 63'h8000_0000;
    dl  = tag3.neg_l ? -$signed({1'b0, s4l[62:32]}) : $signed({1'b0, s4l[62:32]});
    dr  = tag3.neg_r ? -$signed({1'b0, s4r[62:32]}) : $signed({1'b0, s4r[62:32]});
    if (tag3.zero_l) dl = '0;
    if (tag3.zero_r) dr = '0;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      if (!tag3.any) begin
        dn_data.left_speed  <= '0;
        dn_data.right_speed <= '0;
        dn_data.div_fault   <= 1'b0;
      end else if (tag3.sim) begin
        dn_data.left_speed  <= 32'(tag3.sim_left);
        dn_data.right_speed <= 32'(tag3.sim_right);
        dn_data.div_fault   <= 1'b0;
      end else begin
        dn_data.left_speed  <= dl;
        dn_data.right_speed <= dr;
        dn_data.div_fault   <= tag3.den_zero;
      end
    end
  end

endmodule

>>> rtl/diff_drive_motor_velocity_unit.sv
// Top level of the differential drive motor velocity unit: register bank
// and the front, divider and back pipelines. Depends on ddmv_pkg.
//
//   channel  direction  signals                        word
//   cmd      in         cmd_valid / cmd_ready / cmd    cmd_t, six Q4.12 axes
//   spd      out        spd_valid / spd_ready / spd    spd_t, two Q16.16 + fault
//   cfg      in         cfg_we / cfg_index / cfg_wdata register write, no wait
//
// One word is accepted per cycle unless the pipeline is full and stalled; a word
// passes 5 front stages, 32 divider stages at one quotient bit each, 4 back stages.
// Synchronous reset empties the pipeline and loads register defaults.
// Each stage holds while its successor is full and stalled, so empty stages
// keep filling while the output word waits.

module diff_drive_motor_velocity_unit import ddmv_pkg::*; #(
  parameter int CMD_FRAC_BITS = CMD_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        spd_valid,
  input  logic        spd_ready,
  output spd_t        spd
);

  cfg_t cfg;
  logic fe_valid, fe_ready, bk_valid, bk_ready;
  fe_t  fe_data;
  bk_t  bk_data;

  // register bank
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DRIVE_MODE:      cfg.drive_mode      <= cfg_wdata[0];
        REG_RATED_RPM:       cfg.rated_rpm       <= cfg_wdata;
        REG_SIM_SPEED_LIMIT: cfg.sim_speed_limit <= cfg_wdata[14:0];
        REG_LINEAR_GAIN:     cfg.linear_gain     <= cfg_wdata[14:0];
        REG_ANGULAR_GAIN:    cfg.angular_gain    <= cfg_wdata[14:0];
        REG_LINEAR_LIMIT:    cfg.linear_limit    <= cfg_wdata[14:0];
        REG_ANGULAR_LIMIT:   cfg.angular_limit   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  ddmv_front #(
    .CMD_FRAC_BITS(CMD_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (cmd_valid),
    .up_ready (cmd_ready),
    .up_data  (cmd),
    .dn_valid (fe_valid),
    .dn_ready (fe_ready),
    .dn_data  (fe_data)
  );

  ddmv_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fe_valid),
    .up_ready (fe_ready),
    .up_data  (fe_data),
    .dn_valid (bk_valid),
    .dn_ready (bk_ready),
    .dn_data  (bk_data)
  );

  ddmv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (bk_valid),
    .up_ready (bk_ready),
    .up_data  (bk_data),
    .dn_valid (spd_valid),
    .dn_ready (spd_ready),
    .dn_data  (spd)
  );

endmodule

>>> verif/diff_drive_motor_velocity_unit_chk.sv
// Checker for the differential drive motor velocity unit: watches the cmd,
// spd and cfg channels, predicts each speed word and compares it.
// Depends on ddmv_pkg for the word and register types.

module diff_drive_motor_velocity_unit_chk import ddmv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        cmd_valid,
  input  logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic        spd_valid,
  input  logic        spd_ready,
  input  spd_t        spd,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned POLY_A   = 64'd28528;
  localparam longint unsigned POLY_B   = 64'd20080;
  localparam longint unsigned RPM_RADS = 64'd449767923;
  localparam longint unsigned ONE_Q32  = 64'd1 << 32;

  cfg_t shadow_cfg;
  spd_t speed_q[$];
  int   err_cnt;

  assign errors  = err_cnt;
  assign pending = speed_q.size();

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint signed_mag(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_by(longint v, longint unsigned lim);
    longint unsigned a;
    a = magn(v);
    if (a > lim) a = lim;
    return signed_mag(a, v < 0);
  endfunction

  // Restoring division, 32 fraction bits of n/d with n < d
  function automatic longint unsigned frac_bits(longint unsigned n, longint unsigned d);
    longint unsigned q;
    q = 0;
    for (int i = 0; i < 32; i++) begin
      n = n << 1;
      q = q << 1;
      if (n >= d) begin
        n = n - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // One differential motor: ratio to reachable speed, rpm, then rad/s
  function automatic longint motor_rads(longint mot, longint den, longint unsigned aden,
                                        longint unsigned rpm);
    longint unsigned f, m, n, d;
    bit neg;
    if (mot == 0) return 0;
    if (den == 0) begin
      f   = ONE_Q32;
      neg = mot < 0;
    end else begin
      n   = magn(mot) * aden;
      d   = magn(den) << 4;
      f   = (n >= d) ? ONE_Q32 : frac_bits(n, d);
      neg = (mot < 0) != (den < 0);
    end
    m = rpm * f;
    m = (m + 64'h8000) >> 16;
    m = (m * RPM_RADS + 64'h8000_0000) >> 32;
    return signed_mag(m, neg);
  endfunction

  function automatic spd_t predict_speed(cmd_t c, cfg_t k);
    spd_t r;
    longint x, z, lin, ang, lft, rgt, p, q, ax, aden, den;
    longint unsigned mx, lm, am;
    lft = 0;
    rgt = 0;
    r.div_fault = 1'b0;
    if ({c.lin_x, c.lin_y, c.lin_z, c.ang_x, c.ang_y, c.ang_z} != '0) begin
      x = clamp_by(longint'(c.lin_x) * 16, longint'(k.linear_limit) << 4);
      z = clamp_by(longint'(c.ang_z) * 16, longint'(k.angular_limit) << 4);
      if (!k.drive_mode) begin
        mx  = magn(x);
        lm  = (POLY_A * mx * mx + POLY_B * mx * 64'd65536 + 64'h8000_0000) >> 32;
        am  = (longint'(k.angular_gain) * magn(z) + 64'h800) >> 12;
        lin = signed_mag(lm, x < 0);
        ang = signed_mag(am, z < 0);
        lft = clamp_by(lin - ang, longint'(k.sim_speed_limit) << 4);
        rgt = clamp_by(lin + ang, longint'(k.sim_speed_limit) << 4);
      end else begin
        lin = longint'(k.linear_gain) * x;
        ang = longint'(k.angular_gain) * z;
        p   = longint'(k.linear_gain) * longint'(k.linear_limit);
        q   = longint'(k.angular_gain) * longint'(k.angular_limit);
        if (z == 0) begin
          ax   = 1;
          aden = 1;
        end else begin
          ax   = magn(x);
          aden = magn(z);
        end
        den = ax * p + (aden - ax) * q;
        r.div_fault = (den == 0);
        lft = motor_rads(lin - ang, den, aden, k.rated_rpm);
        rgt = motor_rads(lin + ang, den, aden, k.rated_rpm);
      end
    end
    r.left_speed  = lft[31:0];
    r.right_speed = rgt[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    err_cnt++;
  endtask

  // Watch the three channels at every edge
  always @(posedge clk) begin
    spd_t want;
    if (rst) begin
      shadow_cfg <= CFG_RESET;
      speed_q.delete();
      err_cnt = 0;
    end else begin
      if (cmd_valid && cmd_ready) speed_q.push_back(predict_speed(cmd, shadow_cfg));
      if (spd_valid && spd_ready) begin
        if (speed_q.size() == 0) begin
          report_mismatch("unexpected word", spd.left_speed, 0);
        end else begin
          want = speed_q.pop_front();
          if (spd.left_speed !== want.left_speed)
            report_mismatch("left_speed", spd.left_speed, want.left_speed);
          if (spd.right_speed !== want.right_speed)
            report_mismatch("right_speed", spd.right_speed, want.right_speed);
          if (spd.div_fault !== want.div_fault)
            report_mismatch("div_fault", spd.div_fault, want.div_fault);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DRIVE_MODE:      shadow_cfg.drive_mode      <= cfg_wdata[0];
          REG_RATED_RPM:       shadow_cfg.rated_rpm       <= cfg_wdata;
          REG_SIM_SPEED_LIMIT: shadow_cfg.sim_speed_limit <= cfg_wdata[14:0];
          REG_LINEAR_GAIN:     shadow_cfg.linear_gain     <= cfg_wdata[14:0];
          REG_ANGULAR_GAIN:    shadow_cfg.angular_gain    <= cfg_wdata[14:0];
          REG_LINEAR_LIMIT:    shadow_cfg.linear_limit    <= cfg_wdata[14:0];
          REG_ANGULAR_LIMIT:   shadow_cfg.angular_limit   <= cfg_wdata[14:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> verif/diff_drive_motor_velocity_unit_tb.sv
// Testbench top for the differential drive motor velocity unit: clock,
// reset, command and register stimulus, verdict. Depends on ddmv_pkg, the
// rtl top and diff_drive_motor_velocity_unit_chk.

module diff_drive_motor_velocity_unit_tb import ddmv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 50;
  localparam logic [2:0] IDX_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  cmd_t        cmd = '0;
  logic        spd_valid;
  logic        spd_ready = 1'b0;
  spd_t        spd;
  int          errors, pending;
  int          tx_idle = 0, rx_idle = 0;

  diff_drive_motor_velocity_unit dut (.*);
  diff_drive_motor_velocity_unit_chk chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver stall pattern
  always @(posedge clk) spd_ready <= ($urandom_range(99) >= rx_idle);

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic cmd_t mk(int x, int y, int z, int rx, int ry, int rz);
    cmd_t c;
    c.lin_x = x[15:0];
    c.lin_y = y[15:0];
    c.lin_z = z[15:0];
    c.ang_x = rx[15:0];
    c.ang_y = ry[15:0];
    c.ang_z = rz[15:0];
    return c;
  endfunction

  // Drive axis: extremes, small values, or anything
  function automatic logic [15:0] main_axis();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'($signed($urandom_range(4096)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] side_axis();
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000;
  endfunction

  function automatic logic [15:0] pick15();
    case ($urandom_range(4))
      0: return 16'd0;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(8191));
      default: return 16'($urandom_range(32767));
    endcase
  endfunction

  task automatic send_word(cmd_t c);
    if ($urandom_range(99) < tx_idle) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Lower valid and let every outstanding word come back
  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic directed_words();
    send_word(mk(0, 0, 0, 0, 0, 0));
    send_word(mk(0, 1, 0, 0, 0, 0));
    send_word(mk(0, 0, 0, -1, 0, 0));
    send_word(mk(32767, 0, 0, 0, 0, 0));
    send_word(mk(-32768, 0, 0, 0, 0, -32768));
    send_word(mk(0, 0, 0, 0, 0, 32767));
    send_word(mk(2048, 0, 0, 0, 0, -1024));
    send_word(mk(-300, 0, 0, 0, 0, 4000));
  endtask

  task automatic random_config();
    write_reg(REG_DRIVE_MODE, 16'($urandom_range(1)));
    write_reg(REG_RATED_RPM, ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
    write_reg(REG_SIM_SPEED_LIMIT, pick15());
    write_reg(REG_LINEAR_GAIN, pick15());
    write_reg(REG_ANGULAR_GAIN, pick15());
    write_reg(REG_LINEAR_LIMIT, pick15());
    write_reg(REG_ANGULAR_LIMIT, pick15());
  endtask

  initial begin
    cmd_t c;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: sim mode at reset values, then differential mode
    directed_words();
    settle();
    write_reg(REG_DRIVE_MODE, 16'd1);
    write_reg(IDX_UNUSED, 16'hFFFF);
    directed_words();
    settle();
    // Zero reachable speed: no linear gain, straight-line command
    write_reg(REG_LINEAR_GAIN, 16'd0);
    send_word(mk(1000, 0, 0, 0, 0, 0));
    send_word(mk(0, 0, 5, 0, 0, 0));
    send_word(mk(-1000, 0, 0, 0, 0, 0));
    settle();
    // Negative reachable speed: angular term dominates with |x| > |z|
    write_reg(REG_LINEAR_GAIN, 16'd1);
    write_reg(REG_ANGULAR_GAIN, 16'h7FFF);
    write_reg(REG_ANGULAR_LIMIT, 16'h7FFF);
    send_word(mk(8000, 0, 0, 0, 0, 100));
    send_word(mk(-8000, 0, 0, 0, 0, -50));
    settle();
    // Limits clamp a nonzero command to zero
    write_reg(REG_LINEAR_LIMIT, 16'd0);
    write_reg(REG_ANGULAR_LIMIT, 16'd0);
    send_word(mk(5000, 0, 0, 0, 0, 5000));
    settle();
    write_reg(REG_DRIVE_MODE, 16'd0);
    send_word(mk(-5000, 0, 0, 0, 0, 7));
    settle();

    // Random: three stall regimes, five settings each
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 16 : (ph == 1) ? 66 : 0;
      rx_idle = (ph == 0) ? 66 : (ph == 1) ? 16 : 0;
      for (int s = 0; s < 5; s++) begin
        random_config();
        for (int i = 0; i < 50; i++) begin
          if ($urandom_range(15) == 0) c = '0;
          else c = {main_axis(), side_axis(), side_axis(), side_axis(), side_axis(),
                    main_axis()};
          send_word(c);
          if (ph == 1 && s == 2 && i == 25) settle();
        end
        settle();
      end
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
